// ===== hdl/lsmd_pkg.sv =====
// Shared types and constants for the subdivision matrix decode pipeline.
package lsmd_pkg;

    // Field widths
    localparam int IDX_W = 33;
    localparam int ENT_W = 33;

    // Fixed-point one in Q1.32
    localparam logic [ENT_W-1:0] Q_ONE = ENT_W'(64'h1_0000_0000);

    // Depth limit: default and largest supported value
    localparam int MAX_DEPTH_DEF = 32;
    localparam int MAX_DEPTH_LIM = 62;
    localparam int CNT_W         = $clog2(MAX_DEPTH_LIM + 1);

    // Matrix held as three rows of three entries
    typedef logic [2:0][ENT_W-1:0] t_row;
    typedef t_row [2:0]            t_mat;

    // Payload carried from stage to stage
    typedef struct packed {
        logic             started;  // leading one already passed
        logic [CNT_W-1:0] steps;    // split steps applied so far
        logic [IDX_W-1:0] idx;      // heap index of the item
        t_mat             mat;      // matrix built so far
    } t_stage;

endpackage

// ===== hdl/lsmd_split_stage.sv =====
// One pipeline stage: examines one index bit and applies at most one split step.
module lsmd_split_stage #(
    parameter int BIT_POS   = 0,
    parameter int MAX_DEPTH = lsmd_pkg::MAX_DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  lsmd_pkg::t_stage i_data,
    output logic             o_valid,
    output lsmd_pkg::t_stage o_data
);

    logic             r_valid;
    lsmd_pkg::t_stage r_data;
    lsmd_pkg::t_stage n_data;
    logic             w_bit;
    logic             w_apply;

    assign w_bit   = i_data.idx[BIT_POS];
    assign w_apply = i_data.started &&
                     (i_data.steps < lsmd_pkg::CNT_W'(MAX_DEPTH));

    // Split step on every column, or leading-one detect before the first step
    always_comb begin
        logic [lsmd_pkg::ENT_W:0] sum;
        sum    = '0;
        n_data = i_data;
        if (w_apply) begin
            for (int c = 0; c < 3; c++) begin
                sum = {1'b0, i_data.mat[0][c]} + {1'b0, i_data.mat[2][c]};
                n_data.mat[0][c] = w_bit ? i_data.mat[1][c] : i_data.mat[2][c];
                n_data.mat[1][c] = sum[lsmd_pkg::ENT_W:1];
                n_data.mat[2][c] = w_bit ? i_data.mat[0][c] : i_data.mat[1][c];
            end
            n_data.steps = i_data.steps + lsmd_pkg::CNT_W'(1);
        end else if (!i_data.started && w_bit) begin
            n_data.started = 1'b1;
        end
    end

    // Valid bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// ===== hdl/leb_subdivision_matrix_decode_unit.sv =====
// Top level: bisection heap index to 3x3 Q1.32 subdivision matrix, one bit per stage.
//
//  channel  | ports                       | handshake
//  ---------+-----------------------------+------------------------------------------
//  input    | i_heap_index                | taken at a clock edge with start & !busy
//  result   | o_entry_c0_r0..o_entry_c2_r2| valid for one cycle while o_strobe is high
//
// One stage per index bit, most significant first; the number of stages is set by
// the 33-bit index width. A new item can enter every cycle; busy stays low.
// Synchronous active-low reset clears all stage valid bits; payload is not reset.
// The receiver cannot stall, so the pipeline never holds.
module leb_subdivision_matrix_decode_unit #(
    parameter int MAX_DEPTH = lsmd_pkg::MAX_DEPTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [lsmd_pkg::IDX_W-1:0] i_heap_index,
    output logic                       o_strobe,
    output logic [lsmd_pkg::ENT_W-1:0] o_entry_c0_r0,
    output logic [lsmd_pkg::ENT_W-1:0] o_entry_c0_r1,
    output logic [lsmd_pkg::ENT_W-1:0] o_entry_c0_r2,
    output logic [lsmd_pkg::ENT_W-1:0] o_entry_c1_r0,
    output logic [lsmd_pkg::ENT_W-1:0] o_entry_c1_r1,
    output logic [lsmd_pkg::ENT_W-1:0] o_entry_c1_r2,
    output logic [lsmd_pkg::ENT_W-1:0] o_entry_c2_r0,
    output logic [lsmd_pkg::ENT_W-1:0] o_entry_c2_r1,
    output logic [lsmd_pkg::ENT_W-1:0] o_entry_c2_r2
);

    localparam int NSTAGE = lsmd_pkg::IDX_W;

    logic             s_valid [0:NSTAGE];
    lsmd_pkg::t_stage s_data  [0:NSTAGE];
    lsmd_pkg::t_stage w_in_data;

    // Fully pipelined: always ready
    assign busy = 1'b0;

    // Stage input: identity matrix, nothing started
    always_comb begin
        w_in_data.started = 1'b0;
        w_in_data.steps   = '0;
        w_in_data.idx     = i_heap_index;
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                w_in_data.mat[r][c] = (r == c) ? lsmd_pkg::Q_ONE : '0;
            end
        end
    end

    assign s_valid[0] = start && !busy;
    assign s_data[0]  = w_in_data;

    // Split stage chain, one per index bit from the top down
    for (genvar k = 0; k < NSTAGE; k++) begin : g_stage
        lsmd_split_stage #(
            .BIT_POS   (NSTAGE - 1 - k),
            .MAX_DEPTH (MAX_DEPTH)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (s_valid[k]),
            .i_data  (s_data[k]),
            .o_valid (s_valid[k+1]),
            .o_data  (s_data[k+1])
        );
    end

    // Results, column-major from the last stage register
    assign o_strobe      = s_valid[NSTAGE];
    assign o_entry_c0_r0 = s_data[NSTAGE].mat[0][0];
    assign o_entry_c0_r1 = s_data[NSTAGE].mat[1][0];
    assign o_entry_c0_r2 = s_data[NSTAGE].mat[2][0];
    assign o_entry_c1_r0 = s_data[NSTAGE].mat[0][1];
    assign o_entry_c1_r1 = s_data[NSTAGE].mat[1][1];
    assign o_entry_c1_r2 = s_data[NSTAGE].mat[2][1];
    assign o_entry_c2_r0 = s_data[NSTAGE].mat[0][2];
    assign o_entry_c2_r1 = s_data[NSTAGE].mat[1][2];
    assign o_entry_c2_r2 = s_data[NSTAGE].mat[2][2];

endmodule
